[rtl/tboq_pkg.sv]
`timescale 1ns / 1ps

package tboq_pkg;

  localparam int TIME_BITS = 32;
  localparam int RUN_MAX = 255;

  localparam int CONTACT_W = 3;
  localparam int MA_W = 16;
  localparam int NOW_W = 32;
  localparam int WIN_W = 8;
  localparam int MS_W = 16;

  localparam int IN_FIELDS_W = CONTACT_W + MA_W + NOW_W;
  localparam int IN_TDATA_W = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 4;
  localparam int OUT_TDATA_W = 8;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W = 16;

  typedef logic [TIME_BITS-1:0] time_t;
  typedef logic [WIN_W-1:0] run_t;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_SET_THRESHOLD_MA   = 3'd0,
    REG_CLEAR_THRESHOLD_MA = 3'd1,
    REG_SET_WINDOWS        = 3'd2,
    REG_CLEAR_WINDOWS      = 3'd3,
    REG_FREE_SETTLE_MS     = 3'd4,
    REG_SIGNAL_SETTLE_MS   = 3'd5,
    REG_SENSOR_PRESENT     = 3'd6
  } cfg_reg_t;

  localparam logic [MA_W-1:0] SET_THRESHOLD_RST = 16'd50;
  localparam logic [MA_W-1:0] CLEAR_THRESHOLD_RST = 16'd30;
  localparam run_t SET_WINDOWS_RST = 8'd3;
  localparam run_t CLEAR_WINDOWS_RST = 8'd3;
  localparam logic [MS_W-1:0] STABLE_FREE_RST = 16'd500;
  localparam logic [MS_W-1:0] STABLE_SIGNAL_RST = 16'd200;

  // True while a signal that went inactive at since is still inside its window.
  function automatic logic settling(time_t now, time_t since, logic [MS_W-1:0] window);
    time_t diff;
    diff = now - since;
    return diff < time_t'(window);
  endfunction

endpackage

[rtl/track_block_occupancy_qualifier_unit.sv]
`timescale 1ns / 1ps

// Track block occupancy qualifier.
// Each item on the s_axis channel is one sensor sample: three contact bits,
// a track current in mA and a millisecond timestamp. Each sample gives
// exactly one result item on the m_axis channel with the occupied flag, the
// contact and current flags and a really-free verdict.
// The cfg channel writes the thresholds, run windows, settle times and the
// sensor-present flag by register index; it is always ready and is meant to
// be written only while no sample is in flight. Unknown indexes are ignored.
// A sample is registered at the input, then evaluated against the state
// into the output register, where the result becomes valid; one item is
// taken per cycle when the receiver keeps up. The rate is set by the
// single state update per cycle. When the receiver stalls, the result
// register holds, the input register fills and s_axis_tready drops until
// the result is taken.
// Synchronous reset loads the default configuration, clears all flags and
// run counters, and sets every timestamp to zero, which means never.
module track_block_occupancy_qualifier_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // contact_bits [2:0], current_ma [18:3], now_ms [50:19], zero fill above
  input  logic [tboq_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // occupied [0], contact_active [1], current_active [2], really_free [3]
  output logic [tboq_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [tboq_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tboq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import tboq_pkg::*;

  logic [MA_W-1:0] set_threshold_ma;
  logic [MA_W-1:0] clear_threshold_ma;
  run_t set_windows;
  run_t clear_windows;
  logic [MS_W-1:0] free_settle_ms;
  logic [MS_W-1:0] signal_settle_ms;
  logic current_sensor_present;

  logic in_valid;
  logic [CONTACT_W-1:0] in_contact;
  logic [MA_W-1:0] in_ma;
  time_t in_now;

  logic contact_flag, current_flag, occupied_flag;
  run_t occupied_run_count, free_run_count;
  time_t free_since_ms, contact_low_since_ms, current_low_since_ms;

  logic contact_flag_next, current_flag_next, occupied_flag_next;
  run_t occupied_run_count_next, free_run_count_next;
  time_t free_since_ms_next, contact_low_since_ms_next, current_low_since_ms_next;
  logic really_free_next;

  logic out_valid;
  logic [OUT_FIELDS_W-1:0] out_fields;

  logic advance;
  run_t occ_inc, free_inc;
  logic at_set, at_clear;

  assign advance = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || advance;
  assign cfg_ready = 1'b1;
  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata = {{(OUT_TDATA_W - OUT_FIELDS_W){1'b0}}, out_fields};

  assign at_set = in_ma >= set_threshold_ma;
  assign at_clear = in_ma <= clear_threshold_ma;
  assign occ_inc = (occupied_run_count == run_t'(RUN_MAX)) ? occupied_run_count
                                                           : occupied_run_count + run_t'(1);
  assign free_inc = (free_run_count == run_t'(RUN_MAX)) ? free_run_count
                                                        : free_run_count + run_t'(1);

  always_comb begin
    contact_flag_next = |in_contact;
    contact_low_since_ms_next = contact_low_since_ms;
    if (contact_flag_next != contact_flag) begin
      contact_low_since_ms_next = contact_flag_next ? '0 : in_now;
    end

    current_flag_next = current_flag;
    occupied_run_count_next = occupied_run_count;
    free_run_count_next = free_run_count;
    if (!current_sensor_present) begin
      current_flag_next = 1'b0;
      occupied_run_count_next = '0;
      free_run_count_next = '0;
    end else if (!current_flag) begin
      if (at_set) begin
        free_run_count_next = '0;
        if (occ_inc >= set_windows) begin
          current_flag_next = 1'b1;
          occupied_run_count_next = '0;
        end else begin
          occupied_run_count_next = occ_inc;
        end
      end else begin
        occupied_run_count_next = '0;
        if (at_clear) begin
          free_run_count_next = '0;
        end
      end
    end else begin
      if (at_clear) begin
        occupied_run_count_next = '0;
        if (free_inc >= clear_windows) begin
          current_flag_next = 1'b0;
          free_run_count_next = '0;
        end else begin
          free_run_count_next = free_inc;
        end
      end else begin
        free_run_count_next = '0;
        if (at_set) begin
          occupied_run_count_next = '0;
        end
      end
    end

    current_low_since_ms_next = current_low_since_ms;
    if (current_flag_next != current_flag) begin
      current_low_since_ms_next = current_flag_next ? '0 : in_now;
    end

    occupied_flag_next = contact_flag_next || current_flag_next;
    free_since_ms_next = free_since_ms;
    if (occupied_flag_next != occupied_flag) begin
      free_since_ms_next = occupied_flag_next ? '0 : in_now;
    end

    if (occupied_flag_next) begin
      really_free_next = 1'b0;
    end else if (free_since_ms_next == '0) begin
      really_free_next = 1'b1;
    end else begin
      really_free_next =
        !settling(in_now, free_since_ms_next, free_settle_ms) &&
        !(contact_low_since_ms_next != '0 &&
          settling(in_now, contact_low_since_ms_next, signal_settle_ms)) &&
        !(current_low_since_ms_next != '0 &&
          settling(in_now, current_low_since_ms_next, signal_settle_ms));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      set_threshold_ma <= SET_THRESHOLD_RST;
      clear_threshold_ma <= CLEAR_THRESHOLD_RST;
      set_windows <= SET_WINDOWS_RST;
      clear_windows <= CLEAR_WINDOWS_RST;
      free_settle_ms <= STABLE_FREE_RST;
      signal_settle_ms <= STABLE_SIGNAL_RST;
      current_sensor_present <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_SET_THRESHOLD_MA:   set_threshold_ma <= cfg_data;
        REG_CLEAR_THRESHOLD_MA: clear_threshold_ma <= cfg_data;
        REG_SET_WINDOWS:        set_windows <= cfg_data[WIN_W-1:0];
        REG_CLEAR_WINDOWS:      clear_windows <= cfg_data[WIN_W-1:0];
        REG_FREE_SETTLE_MS:     free_settle_ms <= cfg_data;
        REG_SIGNAL_SETTLE_MS:   signal_settle_ms <= cfg_data;
        REG_SENSOR_PRESENT:     current_sensor_present <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tvalid && s_axis_tready) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_contact <= s_axis_tdata[CONTACT_W-1:0];
      in_ma <= s_axis_tdata[CONTACT_W +: MA_W];
      in_now <= time_t'(s_axis_tdata[CONTACT_W + MA_W +: NOW_W]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      contact_flag <= 1'b0;
      current_flag <= 1'b0;
      occupied_flag <= 1'b0;
      occupied_run_count <= '0;
      free_run_count <= '0;
      free_since_ms <= '0;
      contact_low_since_ms <= '0;
      current_low_since_ms <= '0;
    end else if (advance) begin
      contact_flag <= contact_flag_next;
      current_flag <= current_flag_next;
      occupied_flag <= occupied_flag_next;
      occupied_run_count <= occupied_run_count_next;
      free_run_count <= free_run_count_next;
      free_since_ms <= free_since_ms_next;
      contact_low_since_ms <= contact_low_since_ms_next;
      current_low_since_ms <= current_low_since_ms_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_fields <= {really_free_next, current_flag_next, contact_flag_next,
                     occupied_flag_next};
    end
  end

endmodule

[test/tb.sv]
`timescale 1ns / 1ps

module tb;
  import tboq_pkg::*;

  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 3'd7;

  typedef enum {RUN_HIGH, RUN_LOW, RUN_MID, RUN_NOISE} run_kind_t;

  typedef struct packed {
    logic really_free;
    logic current_active;
    logic contact_active;
    logic occupied;
  } verdict_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_TDATA_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b1;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // Configuration as the block should hold it.
  logic [MA_W-1:0] set_thr = SET_THRESHOLD_RST;
  logic [MA_W-1:0] clr_thr = CLEAR_THRESHOLD_RST;
  run_t set_win = SET_WINDOWS_RST;
  run_t clr_win = CLEAR_WINDOWS_RST;
  logic [MS_W-1:0] stable_free = STABLE_FREE_RST;
  logic [MS_W-1:0] stable_signal = STABLE_SIGNAL_RST;
  logic sensor_present = 1'b1;

  // Occupancy state as the block should hold it; a stamp of zero means never.
  logic contact_flag = 1'b0;
  logic current_flag = 1'b0;
  logic occupied_flag = 1'b0;
  run_t occ_run = '0;
  run_t free_run = '0;
  time_t free_since = '0;
  time_t contact_low_since = '0;
  time_t current_low_since = '0;

  verdict_t pending_verdicts[$];
  int errors = 0;
  bit idling = 1'b1;
  time_t sample_ms = '0;
  run_kind_t run_kind = RUN_LOW;
  int run_left = 0;
  logic [CONTACT_W-1:0] contact_hold = '0;

  always #5 clk = ~clk;

  track_block_occupancy_qualifier_unit uut (
    .clk(clk),
    .rst(rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  function automatic verdict_t qualify_sample(logic [CONTACT_W-1:0] contact,
                                              logic [MA_W-1:0] ma, time_t now);
    verdict_t v;
    logic contact_now;
    logic cur_next;
    logic occ_now;
    contact_now = |contact;
    if (contact_now != contact_flag) begin
      contact_flag = contact_now;
      contact_low_since = contact_now ? '0 : now;
    end
    if (!sensor_present) begin
      if (current_flag) begin
        current_flag = 1'b0;
        current_low_since = now;
      end
      occ_run = '0;
      free_run = '0;
    end else begin
      cur_next = current_flag;
      if (!current_flag) begin
        if (ma >= set_thr) begin
          if (occ_run != run_t'(RUN_MAX)) occ_run = occ_run + 1'b1;
          free_run = '0;
          if (occ_run >= set_win) begin
            cur_next = 1'b1;
            occ_run = '0;
            free_run = '0;
          end
        end else begin
          occ_run = '0;
          if (ma <= clr_thr) free_run = '0;
        end
      end else begin
        if (ma <= clr_thr) begin
          if (free_run != run_t'(RUN_MAX)) free_run = free_run + 1'b1;
          occ_run = '0;
          if (free_run >= clr_win) begin
            cur_next = 1'b0;
            occ_run = '0;
            free_run = '0;
          end
        end else begin
          free_run = '0;
          if (ma >= set_thr) occ_run = '0;
        end
      end
      if (cur_next != current_flag) begin
        current_flag = cur_next;
        current_low_since = cur_next ? '0 : now;
      end
    end
    occ_now = contact_flag | current_flag;
    if (occ_now != occupied_flag) begin
      occupied_flag = occ_now;
      free_since = occ_now ? '0 : now;
    end
    v.occupied = occupied_flag;
    v.contact_active = contact_flag;
    v.current_active = current_flag;
    if (occupied_flag) begin
      v.really_free = 1'b0;
    end else if (free_since == '0) begin
      v.really_free = 1'b1;
    end else if (time_t'(now - free_since) < time_t'(stable_free)) begin
      v.really_free = 1'b0;
    end else if (contact_low_since != '0 &&
                 time_t'(now - contact_low_since) < time_t'(stable_signal)) begin
      v.really_free = 1'b0;
    end else if (current_low_since != '0 &&
                 time_t'(now - current_low_since) < time_t'(stable_signal)) begin
      v.really_free = 1'b0;
    end else begin
      v.really_free = 1'b1;
    end
    return v;
  endfunction

  function automatic void check_field(string name, logic want, logic got);
    if (got !== want) begin
      $error("%s: expected %0b, got %0b", name, want, got);
      errors++;
    end
  endfunction

  always @(posedge clk) begin
    verdict_t due;
    verdict_t got;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got = verdict_t'(m_axis_tdata[OUT_FIELDS_W-1:0]);
      if (pending_verdicts.size() == 0) begin
        $error("result item with no sample waiting: %h", m_axis_tdata);
        errors++;
      end else begin
        due = pending_verdicts.pop_front();
        check_field("occupied", due.occupied, got.occupied);
        check_field("contact_active", due.contact_active, got.contact_active);
        check_field("current_active", due.current_active, got.current_active);
        check_field("really_free", due.really_free, got.really_free);
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (idling && $urandom_range(0, 4) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 6)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic send_sample(input logic [CONTACT_W-1:0] contact,
                             input logic [MA_W-1:0] ma, input time_t now);
    if (idling && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= IN_TDATA_W'({now, ma, contact});
    do @(posedge clk); while (!s_axis_tready);
    pending_verdicts.push_back(qualify_sample(contact, ma, now));
  endtask

  task automatic wait_for_results();
    s_axis_tvalid <= 1'b0;
    while (pending_verdicts.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_SET_THRESHOLD_MA:   set_thr = value;
      REG_CLEAR_THRESHOLD_MA: clr_thr = value;
      REG_SET_WINDOWS:        set_win = value[WIN_W-1:0];
      REG_CLEAR_WINDOWS:      clr_win = value[WIN_W-1:0];
      REG_FREE_SETTLE_MS:     stable_free = value;
      REG_SIGNAL_SETTLE_MS:   stable_signal = value;
      REG_SENSOR_PRESENT:     sensor_present = value[0];
      default: ;
    endcase
  endtask

  task automatic finish_writes();
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_config(input logic [CFG_DATA_W-1:0] set_ma, clr_ma, set_w, clr_w,
                            free_ms, signal_ms, present);
    write_reg(REG_SET_THRESHOLD_MA, set_ma);
    write_reg(REG_CLEAR_THRESHOLD_MA, clr_ma);
    write_reg(REG_SET_WINDOWS, set_w);
    write_reg(REG_CLEAR_WINDOWS, clr_w);
    write_reg(REG_FREE_SETTLE_MS, free_ms);
    write_reg(REG_SIGNAL_SETTLE_MS, signal_ms);
    write_reg(REG_SENSOR_PRESENT, present);
    finish_writes();
  endtask

  task automatic random_config(input bit crossed, input bit present);
    int unsigned s;
    int unsigned c;
    s = $urandom_range(20, 4000);
    c = crossed ? $urandom_range(s, 6000) : $urandom_range(0, s);
    set_config(CFG_DATA_W'(s), CFG_DATA_W'(c),
               {8'($urandom), 8'($urandom_range(0, 8))},
               {8'($urandom), 8'($urandom_range(0, 8))},
               CFG_DATA_W'($urandom_range(0, 2000)), CFG_DATA_W'($urandom_range(0, 2000)),
               {15'($urandom), present});
  endtask

  task automatic test_power_up_defaults();
    send_sample(3'b000, 16'd0, 32'd0);
    send_sample(3'b111, 16'hFFFF, 32'd0);
    send_sample(3'b000, 16'hFFFF, 32'd0);
    send_sample(3'b000, 16'd60000, 32'd10);
    send_sample(3'b000, 16'd40, 32'd20);
    send_sample(3'b000, 16'd0, 32'd30);
    send_sample(3'b000, 16'd30, 32'd40);
    send_sample(3'b000, 16'd40, 32'd50);
    send_sample(3'b000, 16'd0, 32'd60);
    send_sample(3'b000, 16'd0, 32'd70);
    send_sample(3'b000, 16'd0, 32'd80);
    send_sample(3'b010, 16'd0, 32'd300);
    send_sample(3'b000, 16'd0, 32'd400);
    send_sample(3'b000, 16'd0, 32'hFFFF_FFFF);
    send_sample(3'b000, 16'd60, 32'd1000);
    send_sample(3'b000, 16'd40, 32'd1010);
    send_sample(3'b000, 16'd60, 32'd1020);
    send_sample(3'b000, 16'd60, 32'd1030);
    send_sample(3'b000, 16'd0, 32'd1040);
  endtask

  task automatic test_sensor_absent_and_zero_windows();
    wait_for_results();
    set_config(16'd50, 16'd30, 16'd0, 16'd0, 16'd0, 16'd0, 16'd1);
    send_sample(3'b000, 16'd100, 32'd2000);
    wait_for_results();
    write_reg(REG_SENSOR_PRESENT, 16'd0);
    finish_writes();
    send_sample(3'b000, 16'd100, 32'd2100);
    wait_for_results();
    write_reg(REG_SENSOR_PRESENT, 16'd1);
    finish_writes();
  endtask

  task automatic test_crossed_thresholds_and_unmapped_index();
    wait_for_results();
    write_reg(REG_UNMAPPED, 16'hFFFF);
    set_config(16'd10, 16'd20, 16'd1, 16'd2, 16'd100, 16'd100, 16'd1);
    send_sample(3'b000, 16'd15, 32'd3000);
    send_sample(3'b000, 16'd15, 32'd3010);
    send_sample(3'b000, 16'd15, 32'd3020);
    send_sample(3'b000, 16'd5, 32'd3030);
  endtask

  // Current comes in runs above, below and between the thresholds, mostly long
  // enough to reach the windows; contacts and time move on around them.
  task automatic test_random_traffic(input int count);
    int i;
    int window_max;
    int step_max;
    logic [CONTACT_W-1:0] contact;
    logic [MA_W-1:0] ma;
    window_max = (set_win > clr_win) ? int'(set_win) : int'(clr_win);
    step_max = ((stable_free > stable_signal) ? int'(stable_free) : int'(stable_signal)) / 8;
    for (i = 0; i < count; i++) begin
      if (run_left <= 0) begin
        case ($urandom_range(0, 9))
          0, 1, 2, 3: run_kind = RUN_HIGH;
          4, 5, 6, 7: run_kind = RUN_LOW;
          8: run_kind = RUN_MID;
          default: run_kind = RUN_NOISE;
        endcase
        run_left = $urandom_range(0, 1) ? window_max + int'($urandom_range(0, 3))
                                         : int'($urandom_range(1, window_max + 3));
      end
      run_left--;
      case (run_kind)
        RUN_HIGH: ma = ($urandom_range(0, 7) == 0) ? set_thr
                                                  : MA_W'($urandom_range(65535, set_thr));
        RUN_LOW: ma = ($urandom_range(0, 7) == 0) ? clr_thr : MA_W'($urandom_range(clr_thr, 0));
        RUN_MID: begin
          if (int'(set_thr) > int'(clr_thr) + 1)
            ma = MA_W'($urandom_range(int'(set_thr) - 1, int'(clr_thr) + 1));
          else
            ma = MA_W'($urandom);
        end
        default: ma = MA_W'($urandom);
      endcase
      if ($urandom_range(0, 5) == 0)
        contact_hold = (contact_hold == '0) ? CONTACT_W'($urandom_range(1, 7)) : '0;
      else if (contact_hold != '0 && $urandom_range(0, 3) == 0)
        contact_hold = CONTACT_W'($urandom_range(1, 7));
      contact = ($urandom_range(0, 19) == 0) ? CONTACT_W'($urandom) : contact_hold;
      case ($urandom_range(0, 31))
        0: sample_ms = $urandom;
        1, 2: sample_ms = sample_ms + $urandom_range(0, 70000);
        3: sample_ms = '0;
        default: sample_ms = sample_ms + $urandom_range(0, step_max + 40);
      endcase
      send_sample(contact, ma, sample_ms);
      if (i == count / 2) wait_for_results();
    end
  endtask

  task automatic test_random_settings();
    int phase;
    wait_for_results();
    set_config(16'd0, 16'd0, 16'd1, 16'd1, 16'd0, 16'd0, 16'd1);
    test_random_traffic(140);
    wait_for_results();
    set_config(16'hFFFF, 16'hFFFF, 16'd255, 16'd255, 16'hFFFF, 16'hFFFF, 16'd1);
    test_random_traffic(300);
    wait_for_results();
    random_config(1'b1, 1'b1);
    test_random_traffic(150);
    wait_for_results();
    random_config(1'b0, 1'b0);
    test_random_traffic(150);
    for (phase = 0; phase < 4; phase++) begin
      wait_for_results();
      random_config(1'b0, 1'b1);
      if (phase == 3) idling = 1'b0;
      test_random_traffic(150);
    end
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    test_power_up_defaults();
    test_sensor_absent_and_zero_windows();
    test_crossed_thresholds_and_unmapped_index();
    test_random_settings();
    wait_for_results();
    repeat (10) @(posedge clk);
    if (errors == 0) begin
      $display("** track_block_occupancy_qualifier_unit: PASSED **");
    end else begin
      $display("** track_block_occupancy_qualifier_unit: FAILED **");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("** track_block_occupancy_qualifier_unit: FAILED **");
    $finish;
  end

endmodule
